// File: rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, codes and helpers for the elevator car controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

  // Sizes of the item fields
  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int FLOOR_W         = 4;
  localparam int TICK_W          = 16;
  localparam int CMD_W           = 3;
  localparam int CFG_IDX_W       = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAINT_ON  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MAINT_OFF = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOP_FLOOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_OPEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_CLOSE = 2'd3;

  // Configuration reset values
  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST  = 4'd5;
  localparam logic [TICK_W-1:0]  TRAVEL_RST     = 16'd10;
  localparam logic [TICK_W-1:0]  DOOR_OPEN_RST  = 16'd30;
  localparam logic [TICK_W-1:0]  DOOR_CLOSE_RST = 16'd30;

  // Request status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Motion codes
  localparam logic [1:0] MOT_IDLE   = 2'd0;
  localparam logic [1:0] MOT_UP     = 2'd1;
  localparam logic [1:0] MOT_DOWN   = 2'd2;
  localparam logic [1:0] MOT_HALTED = 2'd3;

  typedef struct packed {
    logic [FLOOR_W-1:0] top_floor;
    logic [TICK_W-1:0]  travel;
    logic [TICK_W-1:0]  door_open;
    logic [TICK_W-1:0]  door_close;
  } cfg_t;

  // One accepted beat, decoded for the car sequencer
  typedef struct packed {
    logic tick;
    logic level;
    logic open;
    logic close;
    logic maint_on;
    logic maint_off;
  } car_ctl_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic               door_open;
    logic [1:0]         motion;
    logic               emergency;
    logic               maintenance;
    logic               arrived;
  } car_stat_t;

  typedef struct packed {
    car_stat_t          car;
    logic [FLOOR_W-1:0] queued;
    logic [1:0]         status;
  } result_t;

  // A timer load of zero behaves as one
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ecc_ram.sv
// ----------------------------------------------------------------------------
// ecc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 10,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/ecc_queue.sv
// ----------------------------------------------------------------------------
// ecc_queue
// Floor request FIFO held in RAM, with the head entry prefetched so that a
// pop sees its data in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_queue #(
  parameter int DEPTH = ecc_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [ecc_pkg::FLOOR_W-1:0] push_data,
  input  wire logic                        pop,
  output logic                             empty,
  output logic                             full,
  output logic      [ecc_pkg::FLOOR_W-1:0] head_data,
  output logic      [CNT_W-1:0]            count_next
);

  import ecc_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0]  head;
  logic [ADDR_W-1:0]  tail;
  logic [ADDR_W-1:0]  head_next;
  logic [ADDR_W-1:0]  tail_next;
  logic [CNT_W-1:0]   count;
  logic [FLOOR_W-1:0] ram_q;
  logic               byp_valid;
  logic [FLOOR_W-1:0] byp_data;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and fill level
  always_comb begin
    head_next  = pop  ? wrap_inc(head) : head;
    tail_next  = push ? wrap_inc(tail) : tail;
    count_next = CNT_W'(count + CNT_W'(push) - CNT_W'(pop));
  end

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Read ahead at the next head; a write to that entry in the same cycle
  // is forwarded, since the RAM returns the old contents
  ecc_ram #(
    .WIDTH (FLOOR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (push_data),
    .raddr (head_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= push_data;
  end

  assign head_data = byp_valid ? byp_data : ram_q;

endmodule

`default_nettype wire

// File: rtl/ecc_car.sv
// ----------------------------------------------------------------------------
// ecc_car
// Car sequencer: floor position, phase timer, door, emergency latch and
// manual door timer, updated once per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_car (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ecc_pkg::cfg_t               cfg,
  input  wire ecc_pkg::car_ctl_t           ctl,
  input  wire logic                        queue_empty,
  input  wire logic [ecc_pkg::FLOOR_W-1:0] head_data,
  output logic                             pop,
  output ecc_pkg::car_stat_t               stat
);

  import ecc_pkg::*;

  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_MOVING       = 3'd1;
  localparam logic [2:0] PH_HALTED       = 3'd2;
  localparam logic [2:0] PH_DOOR_OPEN    = 3'd3;
  localparam logic [2:0] PH_DOOR_CLOSING = 3'd4;

  logic [FLOOR_W-1:0] floor_now, floor_now_next;
  logic [FLOOR_W-1:0] goal, goal_next;
  logic [2:0]         phase, phase_next;
  logic [TICK_W-1:0]  timer, timer_next;
  logic [TICK_W-1:0]  mtimer, mtimer_next;
  logic               last_btn, last_btn_next;
  logic               emerg, emerg_next;
  logic               maint, maint_next;
  logic               door, door_next;
  logic               open_here;
  logic               arrived;
  logic [1:0]         motion;

  // Work out the next state for this beat
  always_comb begin
    floor_now_next = floor_now;
    goal_next      = goal;
    phase_next     = phase;
    timer_next     = timer;
    mtimer_next    = mtimer;
    last_btn_next  = last_btn;
    emerg_next     = emerg;
    maint_next     = maint;
    door_next      = door;
    open_here      = 1'b0;
    pop            = 1'b0;

    if (ctl.tick) begin
      // Falling edge of the button toggles emergency
      if (last_btn && !ctl.level) begin
        emerg_next = !emerg;
      end
      last_btn_next = ctl.level;

      // Count down the manual door timer
      if (mtimer != '0) begin
        mtimer_next = mtimer - 1'b1;
        if (mtimer == TICK_W'(1)) begin
          door_next = 1'b0;
        end
      end

      case (phase)
        PH_IDLE: begin
          if (!queue_empty && !door_next) begin
            pop       = 1'b1;
            goal_next = head_data;
            if (head_data == floor_now) begin
              if (emerg_next) begin
                phase_next = PH_HALTED;
              end else begin
                open_here = 1'b1;
              end
            end else begin
              phase_next = PH_MOVING;
              timer_next = at_least_one(cfg.travel);
            end
          end
        end
        PH_MOVING: begin
          if (emerg_next) begin
            phase_next = PH_HALTED;
          end else if (timer <= TICK_W'(1)) begin
            if (floor_now < goal) begin
              floor_now_next = floor_now + 1'b1;
            end else if (floor_now > goal) begin
              floor_now_next = floor_now - 1'b1;
            end
            if (floor_now_next == goal) begin
              open_here = 1'b1;
            end else begin
              timer_next = at_least_one(cfg.travel);
            end
          end else begin
            timer_next = timer - 1'b1;
          end
        end
        PH_HALTED: begin
          if (!emerg_next) begin
            open_here = 1'b1;
          end
        end
        PH_DOOR_OPEN: begin
          if (timer <= TICK_W'(1)) begin
            door_next  = 1'b0;
            phase_next = PH_DOOR_CLOSING;
            timer_next = at_least_one(cfg.door_close);
          end else begin
            timer_next = timer - 1'b1;
          end
        end
        default: begin
          if (timer <= TICK_W'(1)) begin
            phase_next = PH_IDLE;
            timer_next = '0;
          end else begin
            timer_next = timer - 1'b1;
          end
        end
      endcase

      // Open the door at the current floor
      if (open_here) begin
        door_next  = 1'b1;
        phase_next = PH_DOOR_OPEN;
        timer_next = at_least_one(cfg.door_open);
      end
    end else if (ctl.open) begin
      if (!door) begin
        door_next   = 1'b1;
        mtimer_next = at_least_one(cfg.door_open);
      end
    end else if (ctl.close) begin
      if (door) begin
        door_next   = 1'b0;
        mtimer_next = '0;
      end
    end else if (ctl.maint_on) begin
      maint_next = 1'b1;
    end else if (ctl.maint_off) begin
      maint_next = 1'b0;
    end
  end

  assign arrived = open_here && (floor_now_next == goal_next);

  // Report motion from the updated phase
  always_comb begin
    case (phase_next)
      PH_MOVING: motion = (goal_next > floor_now_next) ? MOT_UP : MOT_DOWN;
      PH_HALTED: motion = MOT_HALTED;
      default:   motion = MOT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_now <= FLOOR_W'(1);
      goal      <= FLOOR_W'(1);
      phase     <= PH_IDLE;
      timer     <= '0;
      mtimer    <= '0;
      last_btn  <= 1'b1;
      emerg     <= 1'b0;
      maint     <= 1'b0;
      door      <= 1'b0;
    end else begin
      floor_now <= floor_now_next;
      goal      <= goal_next;
      phase     <= phase_next;
      timer     <= timer_next;
      mtimer    <= mtimer_next;
      last_btn  <= last_btn_next;
      emerg     <= emerg_next;
      maint     <= maint_next;
      door      <= door_next;
    end
  end

  assign stat.floor       = floor_now_next;
  assign stat.door_open   = door_next;
  assign stat.motion      = motion;
  assign stat.emergency   = emerg_next;
  assign stat.maintenance = maint_next;
  assign stat.arrived     = arrived;

endmodule

`default_nettype wire

// File: rtl/elevator_car_controller_core.sv
// ----------------------------------------------------------------------------
// elevator_car_controller_core
// Single-car elevator controller with a RAM-backed floor request queue.
// ----------------------------------------------------------------------------
// Every input beat (tick, floor request, door command or maintenance command)
// produces exactly one status beat. A beat is taken every clock cycle while
// in_ready is high: its effect is worked out in the cycle it is accepted and
// the status is registered in the output stage. A two-deep output stage
// (register plus skid) keeps the input ready while one status beat waits;
// ready drops only once a second beat is held back. The request queue lives
// in a RAM whose head entry is prefetched, so a pop needs no wait for its
// data. Configuration writes are taken in any cycle, ready is always high,
// and should be made while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_car_controller_core #(
  parameter int QUEUE_DEPTH = ecc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Item input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ecc_pkg::CMD_W-1:0]     command,
  input  wire logic [ecc_pkg::FLOOR_W-1:0]   floor_number,
  input  wire logic                          button_level,
  // Result output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ecc_pkg::FLOOR_W-1:0]   current_floor,
  output logic                               door_is_open,
  output logic      [1:0]                    motion,
  output logic                               emergency_on,
  output logic                               maintenance_on,
  output logic      [ecc_pkg::FLOOR_W-1:0]   queued_requests,
  output logic      [1:0]                    request_status,
  output logic                               arrived,
  // Configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ecc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ecc_pkg::TICK_W-1:0]    cfg_data
);

  import ecc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t               cfg;
  car_ctl_t           ctl;
  car_stat_t          stat;
  result_t            res;
  result_t            out_q;
  result_t            skid_q;
  logic               skid_valid;
  logic               accept;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  logic [FLOOR_W-1:0] q_head;
  logic [CNT_W-1:0]   q_count_next;
  logic               req_invalid;
  logic [1:0]         status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_floor  <= TOP_FLOOR_RST;
      cfg.travel     <= TRAVEL_RST;
      cfg.door_open  <= DOOR_OPEN_RST;
      cfg.door_close <= DOOR_CLOSE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOP_FLOOR:  cfg.top_floor  <= cfg_data[FLOOR_W-1:0];
        REG_TRAVEL:     cfg.travel     <= cfg_data;
        REG_DOOR_OPEN:  cfg.door_open  <= cfg_data;
        REG_DOOR_CLOSE: cfg.door_close <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Decode the accepted beat
  always_comb begin
    ctl.tick      = accept && (command == CMD_TICK);
    ctl.level     = button_level;
    ctl.open      = accept && (command == CMD_OPEN);
    ctl.close     = accept && (command == CMD_CLOSE);
    ctl.maint_on  = accept && (command == CMD_MAINT_ON);
    ctl.maint_off = accept && (command == CMD_MAINT_OFF);
  end

  // Validate floor requests and push accepted ones
  always_comb begin
    req_invalid = (floor_number == '0) || (floor_number > cfg.top_floor);
    q_push      = 1'b0;
    status      = ST_NONE;
    if (command == CMD_REQUEST) begin
      if (req_invalid) begin
        status = ST_INVALID;
      end else if (q_full) begin
        status = ST_FULL;
      end else begin
        status = ST_ACCEPTED;
        q_push = accept;
      end
    end
  end

  ecc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (floor_number),
    .pop        (q_pop),
    .empty      (q_empty),
    .full       (q_full),
    .head_data  (q_head),
    .count_next (q_count_next)
  );

  ecc_car u_car (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctl         (ctl),
    .queue_empty (q_empty),
    .head_data   (q_head),
    .pop         (q_pop),
    .stat        (stat)
  );

  always_comb begin
    res.car    = stat;
    res.queued = FLOOR_W'(q_count_next);
    res.status = status;
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign current_floor   = out_q.car.floor;
  assign door_is_open    = out_q.car.door_open;
  assign motion          = out_q.car.motion;
  assign emergency_on    = out_q.car.emergency;
  assign maintenance_on  = out_q.car.maintenance;
  assign arrived         = out_q.car.arrived;
  assign queued_requests = out_q.queued;
  assign request_status  = out_q.status;

endmodule

`default_nettype wire

// File: rtl/ecc_checker.sv
// ----------------------------------------------------------------------------
// ecc_checker
// Port-level checks on the status channel of the elevator controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ecc_pkg::FLOOR_W-1:0] current_floor,
  input wire logic                        door_is_open,
  input wire logic [1:0]                  motion,
  input wire logic                        emergency_on,
  input wire logic                        arrived
);

  import ecc_pkg::*;

  // A stalled status beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_floor)
                                && $stable(motion) && $stable(arrived))
    else $error("status beat changed while stalled");

  // A halted car is always under emergency
  a_halt_emerg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (motion == MOT_HALTED) |-> emergency_on)
    else $error("car halted without emergency");

  // Arrival opens the door
  a_arrive_door: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> door_is_open)
    else $error("arrival with door closed");

  // The car is standing when it arrives
  a_arrive_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> (motion == MOT_IDLE))
    else $error("arrival while moving");

endmodule

bind elevator_car_controller_core ecc_checker u_ecc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .current_floor (current_floor),
  .door_is_open  (door_is_open),
  .motion        (motion),
  .emergency_on  (emergency_on),
  .arrived       (arrived)
);

`default_nettype wire
